### sv/kmat_pkg.sv
// ----------------------------------------------------------------------------
// kmat_pkg
// shared types and codes of the keyed mass accumulate table
// ----------------------------------------------------------------------------
`default_nettype none

package kmat_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_ADD       = 3'd0,
        OP_SET_BY_KEY     = 3'd1,
        OP_SET_BY_INDEX   = 3'd2,
        OP_LOOKUP         = 3'd3,
        OP_ERASE_BY_KEY   = 3'd4,
        OP_ERASE_BY_INDEX = 3'd5,
        OP_CLEAR          = 3'd6,
        OP_READ_BY_INDEX  = 3'd7
    } t_op;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // command item, lowest bit first: op, key, mass, index
    typedef struct packed {
        logic [5:0]  index;
        logic [31:0] mass;
        logic [31:0] key;
        t_op         op;
    } t_cmd;

    // result item, lowest bit first: found, index, mass, key, count, status
    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  entry_count;
        logic [31:0] entry_key;
        logic [31:0] entry_mass;
        logic [5:0]  entry_index;
        logic        found;
    } t_result;

endpackage

`default_nettype wire

### sv/keyed_mass_accumulate_table.sv
// ----------------------------------------------------------------------------
// keyed_mass_accumulate_table
// insertion-ordered (key, mass) table with saturating accumulate
// ----------------------------------------------------------------------------
// Commands enter on the s_axis channel, one result item per command leaves
// on the m_axis channel. Entries live in one synchronous memory; the
// sequencer works on one command at a time.
// Key operations scan the entries in order from index 0 until the key is
// found or all valid entries are read; an erase then shifts the entries
// behind the one removed one place down. Scan and shift read one entry per
// cycle through the single read port of the entry memory.
// The sequencer takes the next command once the result has moved into the
// output register.
// A command is taken while the previous result still waits; a stalled
// receiver holds m_axis_tdata and stops further input once that result
// register and the sequencer are both occupied.
// Reset empties the table at once (count to zero, no clearing pass); the
// memory contents are left as they are and are never read beyond count.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_mass_accumulate_table #(
    parameter int CAPACITY   = 64,
    parameter int KEY_WIDTH  = 32,
    parameter int MASS_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [79:0] s_axis_tdata,   // op, key, mass, index
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [79:0] m_axis_tdata    // found, entry_index, entry_mass,
                                             // entry_key, entry_count, status
);

    localparam int AW = $clog2(CAPACITY);
    localparam int DW = KEY_WIDTH + MASS_WIDTH;

    kmat_pkg::t_cmd    w_cmd;
    kmat_pkg::t_result w_res;
    kmat_pkg::t_result r_out;
    logic              r_out_valid;
    logic              w_res_valid, w_res_ready;
    logic              w_wr_en, w_rd_en;
    logic [AW-1:0]     w_wr_addr, w_rd_addr;
    logic [DW-1:0]     w_wr_data, w_rd_data;

    assign w_cmd       = kmat_pkg::t_cmd'(s_axis_tdata[$bits(kmat_pkg::t_cmd)-1:0]);
    assign w_res_ready = !r_out_valid || m_axis_tready;

    kmat_ctrl #(
        .CAPACITY   (CAPACITY),
        .KEY_WIDTH  (KEY_WIDTH),
        .MASS_WIDTH (MASS_WIDTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (s_axis_tvalid),
        .o_cmd_ready (s_axis_tready),
        .i_cmd       (w_cmd),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data),
        .o_rd_en     (w_rd_en),
        .o_rd_addr   (w_rd_addr),
        .i_rd_data   (w_rd_data)
    );

    kmat_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (DW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_ready) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(r_out.entry_count) <= 32'(CAPACITY)))
        else $error("entry count above capacity");

    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.found) |-> (r_out.status == kmat_pkg::ST_OK))
        else $error("found item with error status");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res_valid |-> !s_axis_tready)
        else $error("command taken while a result is pending");
`endif

endmodule

`default_nettype wire

### sv/kmat_mem.sv
// ----------------------------------------------------------------------------
// kmat_mem
// entry memory, one write port and one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module kmat_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [DW-1:0] i_wr_data,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    output      logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

### sv/kmat_ctrl.sv
// ----------------------------------------------------------------------------
// kmat_ctrl
// sequencer: key scan, read-modify-write of one entry, tail shift on erase
// ----------------------------------------------------------------------------
`default_nettype none

module kmat_ctrl #(
    parameter int CAPACITY   = 64,
    parameter int KEY_WIDTH  = 32,
    parameter int MASS_WIDTH = 32,
    localparam int AW = $clog2(CAPACITY),
    localparam int DW = KEY_WIDTH + MASS_WIDTH
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cmd_valid,
    output      logic              o_cmd_ready,
    input  wire kmat_pkg::t_cmd    i_cmd,
    output      logic              o_res_valid,
    input  wire logic              i_res_ready,
    output      kmat_pkg::t_result o_res,
    output      logic              o_wr_en,
    output      logic [AW-1:0]     o_wr_addr,
    output      logic [DW-1:0]     o_wr_data,
    output      logic              o_rd_en,
    output      logic [AW-1:0]     o_rd_addr,
    input  wire logic [DW-1:0]     i_rd_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int KW = KEY_WIDTH;
    localparam int MW = MASS_WIDTH;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_ACT   = 5'b00100,
        S_SHIFT = 5'b01000,
        S_RESP  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    kmat_pkg::t_op     r_op, n_op;
    logic [KW-1:0]     r_key, n_key;
    logic [MW-1:0]     r_mass, n_mass;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ptr, n_ptr;
    logic [AW-1:0]     r_cmp, n_cmp;
    logic              r_pend, n_pend;
    kmat_pkg::t_result r_res, n_res;

    logic [63:0]   w_cmd_key64, w_cmd_mass64;
    logic [63:0]   w_key64, w_mass64, w_rd_key64, w_rd_mass64, w_sat64;
    logic [31:0]   w_idx32, w_count32, w_cmp32;
    logic [KW-1:0] w_rd_key;
    logic [MW-1:0] w_rd_mass, w_sat;
    logic [MW:0]   w_sum;
    logic          w_hit, w_idx_ok;

    assign w_cmd_key64  = 64'(i_cmd.key);
    assign w_cmd_mass64 = 64'(i_cmd.mass);
    assign w_rd_key     = i_rd_data[DW-1:MW];
    assign w_rd_mass    = i_rd_data[MW-1:0];
    assign w_key64      = 64'(r_key);
    assign w_mass64     = 64'(r_mass);
    assign w_rd_key64   = 64'(w_rd_key);
    assign w_rd_mass64  = 64'(w_rd_mass);
    assign w_idx32      = 32'(i_cmd.index);
    assign w_count32    = 32'(r_count);
    assign w_cmp32      = 32'(r_cmp);
    assign w_idx_ok     = w_idx32 < w_count32;
    assign w_hit        = r_pend && (w_rd_key == r_key);

    // saturating accumulate
    assign w_sum   = {1'b0, w_rd_mass} + {1'b0, r_mass};
    assign w_sat   = w_sum[MW] ? {MW{1'b1}} : w_sum[MW-1:0];
    assign w_sat64 = 64'(w_sat);

    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_key       = r_key;
        n_mass      = r_mass;
        n_count     = r_count;
        n_ptr       = r_ptr;
        n_cmp       = r_cmp;
        n_pend      = r_pend;
        n_res       = r_res;
        o_cmd_ready = 1'b0;
        o_res_valid = 1'b0;
        o_wr_en     = 1'b0;
        o_wr_addr   = r_cmp;
        o_wr_data   = i_rd_data;
        o_rd_en     = 1'b0;
        o_rd_addr   = r_ptr[AW-1:0];

        case (r_state)
            S_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_op   = i_cmd.op;
                    n_key  = w_cmd_key64[KW-1:0];
                    n_mass = w_cmd_mass64[MW-1:0];
                    n_res  = '0;
                    n_ptr  = '0;
                    n_pend = 1'b0;
                    case (i_cmd.op)
                        kmat_pkg::OP_CLEAR: begin
                            n_count = '0;
                            n_state = S_RESP;
                        end
                        kmat_pkg::OP_SET_BY_INDEX, kmat_pkg::OP_ERASE_BY_INDEX,
                        kmat_pkg::OP_READ_BY_INDEX: begin
                            if (w_idx_ok) begin
                                o_rd_en   = 1'b1;
                                o_rd_addr = w_idx32[AW-1:0];
                                n_cmp     = w_idx32[AW-1:0];
                                n_state   = S_ACT;
                            end else begin
                                n_res.status = kmat_pkg::ST_RANGE;
                                n_state      = S_RESP;
                            end
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end

            S_SCAN: begin
                if (w_hit) begin
                    n_state = S_ACT;
                end else if (r_ptr < r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr[AW-1:0];
                    n_cmp     = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    // key not present
                    n_res.entry_key = w_key64[31:0];
                    if (r_op == kmat_pkg::OP_PUSH_ADD) begin
                        if (w_count32 < 32'(CAPACITY)) begin
                            o_wr_en           = 1'b1;
                            o_wr_addr         = r_count[AW-1:0];
                            o_wr_data         = {r_key, r_mass};
                            n_res.entry_index = w_count32[5:0];
                            n_res.entry_mass  = w_mass64[31:0];
                            n_count           = r_count + CW'(1);
                        end else begin
                            n_res.status = kmat_pkg::ST_FULL;
                        end
                    end
                    n_state = S_RESP;
                end
            end

            S_ACT: begin
                n_res.found       = 1'b1;
                n_res.entry_index = w_cmp32[5:0];
                n_res.entry_key   = w_rd_key64[31:0];
                n_res.entry_mass  = w_rd_mass64[31:0];
                n_state           = S_RESP;
                case (r_op)
                    kmat_pkg::OP_PUSH_ADD: begin
                        o_wr_en          = 1'b1;
                        o_wr_data        = {w_rd_key, w_sat};
                        n_res.entry_mass = w_sat64[31:0];
                    end
                    kmat_pkg::OP_SET_BY_KEY, kmat_pkg::OP_SET_BY_INDEX: begin
                        o_wr_en          = 1'b1;
                        o_wr_data        = {w_rd_key, r_mass};
                        n_res.entry_mass = w_mass64[31:0];
                    end
                    kmat_pkg::OP_ERASE_BY_KEY, kmat_pkg::OP_ERASE_BY_INDEX: begin
                        n_ptr   = CW'(w_cmp32 + 32'd1);
                        n_pend  = 1'b0;
                        n_state = S_SHIFT;
                    end
                    default: begin
                    end
                endcase
            end

            S_SHIFT: begin
                // write back entry r_cmp one place down while reading the next
                if (r_pend) begin
                    o_wr_en   = 1'b1;
                    o_wr_addr = r_cmp - AW'(1);
                    o_wr_data = i_rd_data;
                end
                if (r_ptr < r_count) begin
                    o_rd_en   = 1'b1;
                    o_rd_addr = r_ptr[AW-1:0];
                    n_cmp     = r_ptr[AW-1:0];
                    n_ptr     = r_ptr + CW'(1);
                    n_pend    = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count = r_count - CW'(1);
                        n_state = S_RESP;
                    end
                end
            end

            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res             = r_res;
        o_res.entry_count = w_count32[6:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_key  <= n_key;
        r_mass <= n_mass;
        r_ptr  <= n_ptr;
        r_cmp  <= n_cmp;
        r_res  <= n_res;
    end

endmodule

`default_nettype wire

### test/tb_keyed_mass_accumulate_table.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyed_mass_accumulate_table
// self-checking bench for the keyed mass accumulate table
// ----------------------------------------------------------------------------
// Every accepted command updates a behavioral copy of the table and queues
// the result item it should produce; each result item leaving the block is
// compared field by field with the oldest queued one. Directed tests cover
// append, saturating accumulate, key and index operations, erase with tail
// shift, clear and the full table; random traffic follows under three
// idling profiles on the command and result sides.
// ----------------------------------------------------------------------------

module tb_keyed_mass_accumulate_table;

    localparam int DEPTH      = 64;
    localparam int STALL_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;  // op, key, mass, index
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;        // found, entry_index, entry_mass,
                                      // entry_key, entry_count, status

    keyed_mass_accumulate_table u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // behavioral copy of the table
    logic [31:0] tbl_key  [DEPTH];
    logic [31:0] tbl_mass [DEPTH];
    int          tbl_used;

    logic [31:0]       key_pool [16];
    kmat_pkg::t_result pending_results [$];
    int                send_idle_pct;
    int                recv_idle_pct;
    int                err_count;
    int                stall_cycles;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic int find_entry(input logic [31:0] key);
        for (int i = 0; i < tbl_used; i++) begin
            if (tbl_key[i] == key) return i;
        end
        return -1;
    endfunction

    function automatic void remove_entry(input int pos);
        for (int i = pos; i + 1 < tbl_used; i++) begin
            tbl_key[i]  = tbl_key[i + 1];
            tbl_mass[i] = tbl_mass[i + 1];
        end
        tbl_used--;
    endfunction

    function automatic kmat_pkg::t_result apply_to_table(input kmat_pkg::t_cmd c);
        kmat_pkg::t_result r;
        int                pos;
        logic [32:0]       sum;
        r = '0;
        case (c.op)
            kmat_pkg::OP_PUSH_ADD: begin
                pos = find_entry(c.key);
                r.entry_key = c.key;
                if (pos >= 0) begin
                    sum = {1'b0, tbl_mass[pos]} + {1'b0, c.mass};
                    tbl_mass[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                    r.found       = 1'b1;
                    r.entry_index = pos[5:0];
                    r.entry_mass  = tbl_mass[pos];
                end else if (tbl_used < DEPTH) begin
                    tbl_key[tbl_used]  = c.key;
                    tbl_mass[tbl_used] = c.mass;
                    r.entry_index = tbl_used[5:0];
                    r.entry_mass  = c.mass;
                    tbl_used++;
                end else begin
                    r.status = kmat_pkg::ST_FULL;
                end
            end
            kmat_pkg::OP_SET_BY_KEY, kmat_pkg::OP_LOOKUP, kmat_pkg::OP_ERASE_BY_KEY: begin
                pos = find_entry(c.key);
                r.entry_key = c.key;
                if (pos >= 0) begin
                    if (c.op == kmat_pkg::OP_SET_BY_KEY) tbl_mass[pos] = c.mass;
                    r.found       = 1'b1;
                    r.entry_index = pos[5:0];
                    r.entry_mass  = tbl_mass[pos];
                    if (c.op == kmat_pkg::OP_ERASE_BY_KEY) remove_entry(pos);
                end
            end
            kmat_pkg::OP_SET_BY_INDEX, kmat_pkg::OP_ERASE_BY_INDEX,
            kmat_pkg::OP_READ_BY_INDEX: begin
                if (int'(c.index) < tbl_used) begin
                    if (c.op == kmat_pkg::OP_SET_BY_INDEX) tbl_mass[c.index] = c.mass;
                    r.found       = 1'b1;
                    r.entry_index = c.index;
                    r.entry_mass  = tbl_mass[c.index];
                    r.entry_key   = tbl_key[c.index];
                    if (c.op == kmat_pkg::OP_ERASE_BY_INDEX) remove_entry(int'(c.index));
                end else begin
                    r.status = kmat_pkg::ST_RANGE;
                end
            end
            kmat_pkg::OP_CLEAR: begin
                tbl_used = 0;
            end
            default: begin
            end
        endcase
        r.entry_count = tbl_used[6:0];
        return r;
    endfunction

    function automatic void report_mismatch(input kmat_pkg::t_result want,
                                            input kmat_pkg::t_result got);
        $display("%0t: exp/got f %0d/%0d i %0d/%0d m %h/%h k %h/%h c %0d/%0d s %0d/%0d",
                 $realtime, want.found, got.found,
                 want.entry_index, got.entry_index,
                 want.entry_mass, got.entry_mass,
                 want.entry_key, got.entry_key,
                 want.entry_count, got.entry_count,
                 want.status, got.status);
    endfunction

    task automatic send_cmd(input kmat_pkg::t_op op, input logic [31:0] key,
                            input logic [31:0] mass, input logic [5:0] index);
        kmat_pkg::t_cmd    c;
        kmat_pkg::t_result want;
        c.op    = op;
        c.key   = key;
        c.mass  = mass;
        c.index = index;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, c};
        do @(posedge i_clk); while (!s_axis_tready);
        want = apply_to_table(c);
        pending_results.insert(pending_results.size(), want);
    endtask

    // result side: random stall and check of each accepted item
    always @(posedge i_clk) begin : result_check
        kmat_pkg::t_result got;
        kmat_pkg::t_result want;
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = kmat_pkg::t_result'(m_axis_tdata);
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= 10)
                    $display("%0t: unexpected result item %h", $realtime, got);
            end else begin
                want = pending_results.pop_front();
                if (got.found !== want.found || got.entry_index !== want.entry_index ||
                    got.entry_mass !== want.entry_mass ||
                    got.entry_key !== want.entry_key ||
                    got.entry_count !== want.entry_count ||
                    got.status !== want.status) begin
                    err_count++;
                    if (err_count <= 10) report_mismatch(want, got);
                end
            end
        end
    end

    // watchdog on cycles without any accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic test_push_accumulate();
        send_cmd(kmat_pkg::OP_CLEAR, 32'd0, 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'h0000_0000, 32'h0000_0000, 6'd0);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'h0000_0000, 32'h0000_0001, 6'd0);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'hFFFF_FFFF, 32'h0000_0001, 6'd0);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'h0000_0005, 32'h4000_0000, 6'd0);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'h0000_0005, 32'hC000_0000, 6'd0);
    endtask

    task automatic test_key_ops();
        send_cmd(kmat_pkg::OP_SET_BY_KEY, 32'h0000_0005, 32'h0000_007B, 6'd0);
        send_cmd(kmat_pkg::OP_SET_BY_KEY, 32'h0000_004D, 32'h1234_5678, 6'd0);
        send_cmd(kmat_pkg::OP_LOOKUP, 32'h0000_0000, 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_LOOKUP, 32'h0000_0063, 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_ERASE_BY_KEY, 32'h0000_0000, 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_ERASE_BY_KEY, 32'h0000_0000, 32'd0, 6'd0);
    endtask

    task automatic test_index_ops();
        send_cmd(kmat_pkg::OP_SET_BY_INDEX, 32'd0, 32'h8000_0000, 6'd0);
        send_cmd(kmat_pkg::OP_SET_BY_INDEX, 32'd0, 32'h0000_0001, 6'd63);
        send_cmd(kmat_pkg::OP_READ_BY_INDEX, 32'd0, 32'd0, 6'd1);
        send_cmd(kmat_pkg::OP_READ_BY_INDEX, 32'd0, 32'd0, 6'd2);
        send_cmd(kmat_pkg::OP_ERASE_BY_INDEX, 32'd0, 32'd0, 6'd1);
        send_cmd(kmat_pkg::OP_ERASE_BY_INDEX, 32'd0, 32'd0, 6'd5);
    endtask

    task automatic test_clear();
        send_cmd(kmat_pkg::OP_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        send_cmd(kmat_pkg::OP_READ_BY_INDEX, 32'd0, 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_LOOKUP, 32'h0000_0005, 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_ERASE_BY_KEY, 32'h0000_0005, 32'd0, 6'd0);
    endtask

    task automatic test_full_table();
        send_cmd(kmat_pkg::OP_CLEAR, 32'd0, 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'h0000_0000, $urandom, 6'd0);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'hFFFF_FFFF, $urandom, 6'd0);
        while (tbl_used < DEPTH)
            send_cmd(kmat_pkg::OP_PUSH_ADD, $urandom, $urandom, 6'($urandom_range(63)));
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'h5A5A_A5A5, 32'h0000_0001, 6'd0);
        send_cmd(kmat_pkg::OP_PUSH_ADD, tbl_key[DEPTH - 1], 32'hFFFF_FFFF, 6'd0);
        send_cmd(kmat_pkg::OP_READ_BY_INDEX, 32'd0, 32'd0, 6'd63);
        send_cmd(kmat_pkg::OP_SET_BY_INDEX, 32'd0, 32'h0000_0000, 6'd63);
        send_cmd(kmat_pkg::OP_LOOKUP, tbl_key[DEPTH - 1], 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_ERASE_BY_INDEX, 32'd0, 32'd0, 6'd63);
        send_cmd(kmat_pkg::OP_READ_BY_INDEX, 32'd0, 32'd0, 6'd63);
        send_cmd(kmat_pkg::OP_PUSH_ADD, 32'h5A5A_A5A5, 32'h3FFF_FFFF, 6'd0);
        send_cmd(kmat_pkg::OP_ERASE_BY_INDEX, 32'd0, 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_ERASE_BY_KEY, tbl_key[0], 32'd0, 6'd0);
        send_cmd(kmat_pkg::OP_CLEAR, 32'd0, 32'd0, 6'd0);
    endtask

    task automatic test_random(input int n_items, input int push_pct);
        kmat_pkg::t_op op;
        logic [31:0]   key;
        logic [31:0]   mass;
        logic [5:0]    index;
        int            r;
        repeat (n_items) begin
            r = $urandom_range(99);
            if (r < push_pct) begin
                op = kmat_pkg::OP_PUSH_ADD;
            end else begin
                r = $urandom_range(99);
                if (r < 16)      op = kmat_pkg::OP_SET_BY_KEY;
                else if (r < 30) op = kmat_pkg::OP_SET_BY_INDEX;
                else if (r < 50) op = kmat_pkg::OP_LOOKUP;
                else if (r < 64) op = kmat_pkg::OP_ERASE_BY_KEY;
                else if (r < 78) op = kmat_pkg::OP_ERASE_BY_INDEX;
                else if (r < 81) op = kmat_pkg::OP_CLEAR;
                else             op = kmat_pkg::OP_READ_BY_INDEX;
            end
            r = $urandom_range(99);
            if (r < 55 && tbl_used > 0) key = tbl_key[$urandom_range(tbl_used - 1)];
            else if (r < 80)            key = key_pool[$urandom_range(15)];
            else                        key = $urandom;
            r = $urandom_range(99);
            if (r < 40)      mass = $urandom;
            else if (r < 60) mass = 32'hFFFF_FFFF - $urandom_range(255);
            else if (r < 75) mass = 32'd0;
            else             mass = $urandom_range(32'h4000_0000);
            if ($urandom_range(99) < 70 && tbl_used > 0)
                index = 6'($urandom_range(tbl_used - 1));
            else
                index = 6'($urandom_range(63));
            send_cmd(op, key, mass, index);
        end
    endtask

    initial begin
        err_count     = 0;
        tbl_used      = 0;
        send_idle_pct = 29;
        recv_idle_pct = 74;
        key_pool[0]   = 32'h0000_0000;
        key_pool[1]   = 32'hFFFF_FFFF;
        for (int i = 2; i < 16; i++) key_pool[i] = $urandom;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_push_accumulate();
        test_key_ops();
        test_index_ops();
        test_clear();
        test_full_table();
        test_random(180, 35);

        send_idle_pct = 74;
        recv_idle_pct = 29;
        test_random(200, 60);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(180, 40);

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

### sim.f
sv/kmat_pkg.sv
sv/kmat_mem.sv
sv/kmat_ctrl.sv
sv/keyed_mass_accumulate_table.sv
test/tb_keyed_mass_accumulate_table.sv
